// ===== rtl/core/lsd_pkg.sv =====
`default_nettype none
package lsd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  STREAM_INFO  = 8'd1;
	localparam logic [7:0]  STREAM_ERROR = 8'd2;
	localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
	localparam logic [2:0]  HDR_LAST     = 3'd7;
	localparam logic [2:0]  LEN_START    = 3'd4;
	localparam logic [15:0] MAX_LEN_RST  = 16'd1024;

	typedef enum logic [1:0] {
		LVL_INFO  = 2'd0,
		LVL_ERROR = 2'd1,
		LVL_CRIT  = 2'd2
	} level_t;

	// One classified input byte: an optional message result, then an
	// optional truncation result.
	typedef struct packed {
		logic       has_msg;
		logic [7:0] msg_byte;
		logic       msg_has_byte;
		logic       msg_end;
		logic       trunc;
		level_t     lvl;
	} rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/lsd_front.sv =====
`default_nettype none
module lsd_front
	import lsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_fire,
	input  wire logic [7:0]  log_byte,
	input  wire logic        end_of_buffer,
	output logic             push,
	output rec_t             push_rec
);

	logic [15:0] max_len_q;
	logic        in_payload_q;
	logic [2:0]  header_pos_q;
	level_t      frame_level_q;
	logic [31:0] payload_len_q;
	logic [31:0] payload_pos_q;

	logic        in_payload_n;
	logic [2:0]  header_pos_n;
	level_t      frame_level_n;
	logic [31:0] payload_len_n;
	logic [31:0] payload_pos_n;
	logic        frame_done;
	logic [31:0] max_len_ext;
	logic [31:0] kept;
	logic [31:0] pos_inc;
	rec_t        rec;

	assign max_len_ext = {16'd0, max_len_q};
	assign kept        = (payload_len_q < max_len_ext) ? payload_len_q : max_len_ext;
	assign pos_inc     = payload_pos_q + 32'd1;

	always_comb begin
		in_payload_n  = in_payload_q;
		header_pos_n  = header_pos_q;
		frame_level_n = frame_level_q;
		payload_len_n = payload_len_q;
		payload_pos_n = payload_pos_q;
		frame_done    = 1'b0;
		rec           = '0;

		if (!in_payload_q) begin
			if (header_pos_q == 3'd0) begin
				priority if (log_byte == STREAM_INFO) begin
					frame_level_n = LVL_INFO;
				end else if (log_byte == STREAM_ERROR) begin
					frame_level_n = LVL_ERROR;
				end else begin
					frame_level_n = LVL_CRIT;
				end
			end else if (header_pos_q >= LEN_START) begin
				payload_len_n = {payload_len_q[23:0], log_byte};
			end
			if (header_pos_q == HDR_LAST) begin
				header_pos_n  = 3'd0;
				payload_pos_n = 32'd0;
				// empty message: closing marker on the last header byte
				if (payload_len_n == 32'd0 || max_len_q == 16'd0) begin
					rec.has_msg = 1'b1;
					rec.msg_end = 1'b1;
				end
				if (payload_len_n == 32'd0) begin
					frame_done = 1'b1;
				end else begin
					in_payload_n = 1'b1;
				end
			end else begin
				header_pos_n = header_pos_q + 3'd1;
			end
		end else begin
			if (pos_inc < kept) begin
				rec.has_msg      = 1'b1;
				rec.msg_byte     = log_byte;
				rec.msg_has_byte = 1'b1;
			end else if (pos_inc == kept) begin
				// last kept byte; a trailing newline is dropped
				rec.has_msg = 1'b1;
				rec.msg_end = 1'b1;
				if (log_byte != NEWLINE_CHAR) begin
					rec.msg_byte     = log_byte;
					rec.msg_has_byte = 1'b1;
				end
			end
			if (pos_inc >= payload_len_q) begin
				in_payload_n  = 1'b0;
				header_pos_n  = 3'd0;
				payload_pos_n = 32'd0;
				frame_done    = 1'b1;
			end else begin
				payload_pos_n = pos_inc;
			end
		end

		if (end_of_buffer && !frame_done && (in_payload_n || header_pos_n != 3'd0)) begin
			rec.trunc     = 1'b1;
			in_payload_n  = 1'b0;
			header_pos_n  = 3'd0;
			payload_pos_n = 32'd0;
		end
		rec.lvl = frame_level_n;
	end

	assign push_rec = rec;
	assign push     = in_fire && (rec.has_msg || rec.trunc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q     <= MAX_LEN_RST;
			in_payload_q  <= 1'b0;
			header_pos_q  <= 3'd0;
			frame_level_q <= LVL_INFO;
			payload_len_q <= 32'd0;
			payload_pos_q <= 32'd0;
		end else begin
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (in_fire) begin
				in_payload_q  <= in_payload_n;
				header_pos_q  <= header_pos_n;
				frame_level_q <= frame_level_n;
				payload_len_q <= payload_len_n;
				payload_pos_q <= payload_pos_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lsd_queue.sv =====
`default_nettype none
module lsd_queue
	import lsd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t push_rec,
	output logic      not_full,
	input  wire logic pop,
	output logic      q_valid,
	output rec_t      q_rec
);

	rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign not_full = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_rec    = mem_q[rd_ptr_q];
	assign do_push  = push && not_full;
	assign do_pop   = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lsd_back.sv =====
`default_nettype none
module lsd_back
	import lsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire rec_t        q_rec,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_byte,
	output logic             has_byte,
	output logic [1:0]       level,
	output logic             message_end,
	output logic             truncated
);

	logic msg_pend_q;
	logic trunc_pend_q;
	rec_t cur_q;
	logic out_fire;
	logic last_fire;
	logic load;

	assign out_valid = msg_pend_q || trunc_pend_q;
	assign out_fire  = out_valid && out_ready;
	assign last_fire = out_fire && !(msg_pend_q && trunc_pend_q);
	assign load      = !out_valid || last_fire;
	assign pop       = load && q_valid;

	// message result goes first, truncation result after it
	assign data_byte   = msg_pend_q ? cur_q.msg_byte : 8'd0;
	assign has_byte    = msg_pend_q && cur_q.msg_has_byte;
	assign message_end = msg_pend_q && cur_q.msg_end;
	assign truncated   = !msg_pend_q && trunc_pend_q;
	assign level       = cur_q.lvl;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_pend_q   <= 1'b0;
			trunc_pend_q <= 1'b0;
		end else if (load) begin
			msg_pend_q   <= q_valid && q_rec.has_msg;
			trunc_pend_q <= q_valid && q_rec.trunc;
		end else if (out_fire) begin
			msg_pend_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/log_stream_deframer_core.sv =====
`default_nettype none
// Multiplexed log stream deframer.
// Input channel (in_valid/in_ready): one raw byte of the log buffer per
// transaction, with end_of_buffer set on the buffer's final byte. Frames are
// an 8-byte header (stream code, three pad bytes, 32-bit big-endian length)
// and a payload. Output channel (out_valid/out_ready): one result per
// transaction: message byte, level, message_end and truncated flags.
// Config: cfg_wr_en/cfg_wr_data write max_message_len at any edge; write it
// only while no transaction is in flight.
// Throughput: one input byte per cycle while the queue has room. A byte makes
// zero, one or two results; one that makes two (truncation) takes two output
// transactions. Header and skipped bytes make none, bar the closing marker of
// an empty message on its last header byte and truncation on end_of_buffer.
// The accepting edge writes the record into a 4-entry queue; the back loads
// it into its output register once that is free. Stall: when out_ready is
// low the back holds its result and the queue takes up to four more records;
// once it is full in_ready drops for every byte, even one that would make no
// result. Reset: parser returns to header state, max_message_len goes to 1024,
// queue and output register empty. No clearing pass is needed.
module log_stream_deframer_core
	import lsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  log_byte,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_byte,
	output logic             has_byte,
	output logic [1:0]       level,
	output logic             message_end,
	output logic             truncated
);

	logic in_fire;
	logic push;
	rec_t push_rec;
	logic q_valid;
	rec_t q_rec;
	logic pop;

	assign in_fire = in_valid && in_ready;

	// front: header/payload parser, classifies each byte
	lsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_fire       (in_fire),
		.log_byte      (log_byte),
		.end_of_buffer (end_of_buffer),
		.push          (push),
		.push_rec      (push_rec)
	);

	// queue decouples parser from output side
	lsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.not_full (in_ready),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_rec    (q_rec)
	);

	// back: expands each record into one or two output transactions
	lsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_rec       (q_rec),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.has_byte    (has_byte),
		.level       (level),
		.message_end (message_end),
		.truncated   (truncated)
	);

	// a queued record reaches an empty output register the next cycle
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !out_valid) |=> out_valid)
		else $error("queued record not loaded into output register");

	// no data byte without has_byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (data_byte == 8'd0))
		else $error("data_byte nonzero without has_byte");

	// a truncation result carries no message content
	a_trunc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && truncated) |-> (!has_byte && !message_end))
		else $error("truncation result carries message content");

endmodule
`default_nettype wire
